// ===== src/battery_power_saving_mode_control_assert.svh =====
// Assertion macros shared by the battery power-saving mode control modules.
// BPSM_ASSERT expects clk and rst_n in the module that uses it; BPSM_ASSERT_ALWAYS expects clk.
`ifndef BATTERY_POWER_SAVING_MODE_CONTROL_ASSERT_SVH
`define BATTERY_POWER_SAVING_MODE_CONTROL_ASSERT_SVH

// Checked only while the block is out of reset.
`define BPSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, during reset as well.
`define BPSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bpsm_pkg.sv =====
// Shared types and constants for the battery power-saving mode control block.
// Has no dependencies; used by every module of the block.
package bpsm_pkg;

    localparam logic [1:0] ACT_REINIT = 2'd0;
    localparam logic [1:0] ACT_MANUAL = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_USB    = 2'd3;

    localparam logic [1:0] CFG_ENTER   = 2'd0;
    localparam logic [1:0] CFG_EXIT    = 2'd1;
    localparam logic [1:0] CFG_CONFIRM = 2'd2;

    localparam logic [6:0] ENTER_RESET   = 7'd20;
    localparam logic [6:0] EXIT_RESET    = 7'd30;
    localparam logic [7:0] CONFIRM_RESET = 8'd3;

    localparam logic [7:0] PERCENT_MAX = 8'd100;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    localparam logic [15:0] RTC_NORMAL_MS     = 16'd1000;
    localparam logic [15:0] RTC_SAVING_MS     = 16'd60000;
    localparam logic [15:0] SENSOR_NORMAL_MS  = 16'd5000;
    localparam logic [15:0] SENSOR_SAVING_MS  = 16'd60000;
    localparam logic [15:0] BATTERY_NORMAL_MS = 16'd30000;
    localparam logic [15:0] BATTERY_SAVING_MS = 16'd10000;

    typedef struct packed {
        logic [6:0] enter_percent;
        logic [6:0] exit_percent;
        logic [7:0] confirm_samples;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic       manual_saving;
        logic       reading_ok;
        logic [7:0] charge_level;
        logic       usb_connected;
    } item_t;

    typedef struct packed {
        logic        status;
        logic        state_changed;
        logic        saving_mode;
        logic        seconds_on;
        logic        net_auto_on;
        logic [15:0] rtc_interval_ms;
        logic [15:0] sensor_interval_ms;
        logic [15:0] battery_interval_ms;
    } result_t;

endpackage

// ===== src/bpsm_cfg.sv =====
// Configuration registers: thresholds and confirmation length.
// Depends on bpsm_pkg.
module bpsm_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [7:0]        wr_data,
    output bpsm_pkg::cfg_t    cfg
);

    bpsm_pkg::cfg_t cfg_reg;
    bpsm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bpsm_pkg::CFG_ENTER:   cfg_next.enter_percent   = wr_data[6:0];
                bpsm_pkg::CFG_EXIT:    cfg_next.exit_percent    = wr_data[6:0];
                bpsm_pkg::CFG_CONFIRM: cfg_next.confirm_samples = wr_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enter_percent   <= bpsm_pkg::ENTER_RESET;
            cfg_reg.exit_percent    <= bpsm_pkg::EXIT_RESET;
            cfg_reg.confirm_samples <= bpsm_pkg::CONFIRM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/bpsm_ctrl.sv =====
// Mode decision: state registers, hysteresis with confirmation, and policy values.
// Depends on bpsm_pkg and the assertion macro header.
`include "battery_power_saving_mode_control_assert.svh"

module bpsm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  bpsm_pkg::item_t     item,
    input  bpsm_pkg::cfg_t      cfg,
    output bpsm_pkg::result_t   res
);

    logic       manual_reg,  manual_next;
    logic       host_reg,    host_next;
    logic       seen_reg,    seen_next;
    logic       latch_reg,   latch_next;
    logic       pdir_reg,    pdir_next;
    logic [7:0] pcount_reg,  pcount_next;
    logic       saving_reg,  saving_next;

    logic       status;
    logic       below_enter;
    logic       above_exit;
    logic       want;
    logic [7:0] count_inc;

    assign below_enter = item.charge_level <= {1'b0, cfg.enter_percent};
    assign above_exit  = item.charge_level >= {1'b0, cfg.exit_percent};
    assign count_inc   = (pcount_reg == bpsm_pkg::COUNT_MAX) ? pcount_reg : pcount_reg + 8'd1;

    always_comb
    begin
        if (!latch_reg && below_enter)
        begin
            want = 1'b1;
        end
        else if (latch_reg && above_exit)
        begin
            want = 1'b0;
        end
        else
        begin
            want = latch_reg;
        end
    end

    always_comb
    begin
        manual_next = manual_reg;
        host_next   = host_reg;
        seen_next   = seen_reg;
        latch_next  = latch_reg;
        pdir_next   = pdir_reg;
        pcount_next = pcount_reg;
        saving_next = saving_reg;
        status      = 1'b0;
        case (item.action)
            bpsm_pkg::ACT_REINIT:
            begin
                manual_next = item.manual_saving;
                host_next   = 1'b0;
                seen_next   = 1'b0;
                latch_next  = 1'b0;
                pdir_next   = 1'b0;
                pcount_next = 8'd0;
                saving_next = item.manual_saving;
            end
            bpsm_pkg::ACT_MANUAL:
            begin
                if (item.manual_saving != manual_reg)
                begin
                    manual_next = item.manual_saving;
                    pdir_next   = latch_reg;
                    pcount_next = 8'd0;
                    saving_next = !host_reg && (item.manual_saving || latch_reg);
                end
            end
            bpsm_pkg::ACT_SAMPLE:
            begin
                if (item.reading_ok && (item.charge_level > bpsm_pkg::PERCENT_MAX))
                begin
                    status = 1'b1;
                end
                else if (!item.reading_ok)
                begin
                    pdir_next   = latch_reg;
                    pcount_next = 8'd0;
                end
                else if (host_reg)
                begin
                    seen_next   = 1'b1;
                    latch_next  = 1'b0;
                    pdir_next   = 1'b0;
                    pcount_next = 8'd0;
                end
                else if (!seen_reg)
                begin
                    seen_next   = 1'b1;
                    latch_next  = below_enter;
                    pdir_next   = below_enter;
                    pcount_next = 8'd0;
                    saving_next = manual_reg || below_enter;
                end
                else if (want == latch_reg)
                begin
                    pdir_next   = latch_reg;
                    pcount_next = 8'd0;
                end
                else if (pdir_reg != want)
                begin
                    pdir_next   = want;
                    pcount_next = 8'd1;
                end
                else if (count_inc >= cfg.confirm_samples)
                begin
                    latch_next  = want;
                    pdir_next   = want;
                    pcount_next = 8'd0;
                    saving_next = manual_reg || want;
                end
                else
                begin
                    pcount_next = count_inc;
                end
            end
            bpsm_pkg::ACT_USB:
            begin
                if (item.usb_connected != host_reg)
                begin
                    host_next = item.usb_connected;
                    if (item.usb_connected)
                    begin
                        latch_next  = 1'b0;
                        seen_next   = 1'b1;
                        pdir_next   = 1'b0;
                        saving_next = 1'b0;
                    end
                    else
                    begin
                        pdir_next   = latch_reg;
                        saving_next = manual_reg || latch_reg;
                    end
                    pcount_next = 8'd0;
                end
            end
            default:
            begin
                status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_reg <= 1'b0;
            host_reg   <= 1'b0;
            seen_reg   <= 1'b0;
            latch_reg  <= 1'b0;
            pdir_reg   <= 1'b0;
            pcount_reg <= 8'd0;
            saving_reg <= 1'b0;
        end
        else if (fire)
        begin
            manual_reg <= manual_next;
            host_reg   <= host_next;
            seen_reg   <= seen_next;
            latch_reg  <= latch_next;
            pdir_reg   <= pdir_next;
            pcount_reg <= pcount_next;
            saving_reg <= saving_next;
        end
    end

    always_comb
    begin
        res.status              = status;
        res.state_changed       = saving_next != saving_reg;
        res.saving_mode         = saving_next;
        res.seconds_on          = !saving_next;
        res.net_auto_on         = !saving_next;
        res.rtc_interval_ms     = saving_next ? bpsm_pkg::RTC_SAVING_MS
                                              : bpsm_pkg::RTC_NORMAL_MS;
        res.sensor_interval_ms  = saving_next ? bpsm_pkg::SENSOR_SAVING_MS
                                              : bpsm_pkg::SENSOR_NORMAL_MS;
        res.battery_interval_ms = saving_next ? bpsm_pkg::BATTERY_SAVING_MS
                                              : bpsm_pkg::BATTERY_NORMAL_MS;
    end

    // A connected host keeps the automatic latch clear and the mode normal.
    `BPSM_ASSERT(a_host_clears_latch, host_reg |-> !latch_reg, "latch set while host connected")
    `BPSM_ASSERT(a_host_forces_normal, host_reg |-> !saving_reg, "saving mode while host connected")
    // An open confirmation run always points away from the current latch.
    `BPSM_ASSERT(a_run_direction, (pcount_reg != 8'd0) |-> (pdir_reg != latch_reg),
                 "open run agrees with latch")

endmodule

// ===== src/battery_power_saving_mode_control.sv =====
// Top level of the battery power-saving mode control block: stream ports,
// input and result registers. Depends on bpsm_pkg, bpsm_cfg and bpsm_ctrl.
`include "battery_power_saving_mode_control_assert.svh"

// Takes one event per clock cycle while the result side takes results, and returns one
// result per event; each event passes through the input register and then the result
// register. The decision logic between them is a few compares and flag updates, so
// throughput is one transaction per cycle for as long as the result side takes
// transactions. The configuration channel is always ready; write it only while no
// event is in flight.
module battery_power_saving_mode_control
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: manual_saving, reading_ok, charge_level[7:0],
    // usb_connected, then zero fill.
    input  logic [15:0] s_tdata,
    // Field: action[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: status, state_changed, saving_mode, seconds_on,
    // net_auto_on, rtc_interval_ms[15:0], sensor_interval_ms[15:0],
    // battery_interval_ms[15:0], then zero fill.
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    bpsm_pkg::cfg_t    cfg;
    bpsm_pkg::item_t   in_item;
    bpsm_pkg::item_t   item_reg;
    bpsm_pkg::result_t res;
    bpsm_pkg::result_t res_reg;
    logic              item_valid_reg;
    logic              item_valid_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              fire;
    logic              take;

    assign cfg_ready = 1'b1;

    bpsm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign in_item.action          = s_tuser;
    assign in_item.manual_saving   = s_tdata[0];
    assign in_item.reading_ok      = s_tdata[1];
    assign in_item.charge_level    = s_tdata[9:2];
    assign in_item.usb_connected   = s_tdata[10];

    assign fire     = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || fire;
    assign take     = s_tvalid && s_tready;

    assign item_valid_next = take || (item_valid_reg && !fire);
    assign res_valid_next  = fire || (res_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    bpsm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {3'b000,
                       res_reg.battery_interval_ms,
                       res_reg.sensor_interval_ms,
                       res_reg.rtc_interval_ms,
                       res_reg.net_auto_on,
                       res_reg.seconds_on,
                       res_reg.saving_mode,
                       res_reg.state_changed,
                       res_reg.status};

    // A stalled result must never be overwritten by the decision stage.
    `BPSM_ASSERT(a_no_overwrite, (res_valid_reg && !m_tready) |-> !fire, "result overwritten")
    // Input side only back-pressures when the input register is occupied.
    `BPSM_ASSERT(a_ready_when_empty, !item_valid_reg |-> s_tready, "not ready while empty")
    // A rejected sample never changes the mode.
    `BPSM_ASSERT(a_reject_no_change, (m_tvalid && m_tdata[0]) |-> !m_tdata[1],
                 "rejected sample changed mode")
    `BPSM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "output valid in reset")

endmodule

// ===== tb/tb_battery_power_saving_mode_control.sv =====
// Self-checking testbench for battery_power_saving_mode_control: directed events from a
// table, then phases of random battery runs under several threshold settings.
// Depends on bpsm_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_battery_power_saving_mode_control;

    import bpsm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        item_t ev;
        logic  pinned;
        logic  p_status;
        logic  p_changed;
        logic  p_saving;
    } step_row_t;

    typedef struct {
        logic [7:0] enter_raw;
        logic [7:0] exit_raw;
        logic [7:0] confirm_raw;
        int         noise;
        int         wild;
        int         min_run;
        int         max_run;
        int         count;
        bit         squeeze;
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = ACT_REINIT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ENTER;
    logic [7:0]  cfg_data = '0;

    // Expected mode state and registers.
    logic       manual_req = 1'b0;
    logic       host_present = 1'b0;
    logic       seen_sample = 1'b0;
    logic       auto_latch = 1'b0;
    logic       run_dir = 1'b0;
    logic [7:0] run_len = '0;
    logic       saving_now = 1'b0;
    logic [6:0] enter_lvl = ENTER_RESET;
    logic [6:0] exit_lvl = EXIT_RESET;
    logic [7:0] confirm_need = CONFIRM_RESET;

    result_t mode_reports_due[$];

    int  errors = 0;
    int  events_sent = 0;
    int  results_seen = 0;
    int  mode_flips = 0;
    int  rejects = 0;
    int  settings_used = 1;
    int  idle_cycles = 0;
    bit  sender_calm = 1'b0;
    bit  sink_calm = 1'b0;
    bit  hold_off_req = 1'b0;
    bit  low_side = 1'b0;
    int  run_left = 0;

    // Columns: action, manual, valid, percent, usb | pinned, status, changed, saving.
    step_row_t script [25] = '{
        '{'{ACT_MANUAL, 1'b0, 1'b1, 8'd0,   1'b1}, 1'b1, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b1, 1'b1, 8'd255, 1'b0}, 1'b1, 1'b1, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd101, 1'b1}, 1'b1, 1'b1, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b0, 8'd255, 1'b0}, 1'b1, 1'b0, 1'b0, 1'b0},
        '{'{ACT_USB,    1'b0, 1'b0, 8'd0,   1'b0}, 1'b1, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd100, 1'b0}, 1'b1, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd20,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd25,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd0,   1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd5,   1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd20,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd29,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd30,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b0, 8'd0,   1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd100, 1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd31,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd99,  1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_MANUAL, 1'b1, 1'b0, 8'd0,   1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_MANUAL, 1'b1, 1'b0, 8'd0,   1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_USB,    1'b0, 1'b0, 8'd0,   1'b1}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_SAMPLE, 1'b0, 1'b1, 8'd0,   1'b1}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_USB,    1'b0, 1'b0, 8'd0,   1'b0}, 1'b0, 1'b0, 1'b0, 1'b0},
        '{'{ACT_REINIT, 1'b0, 1'b1, 8'd50,  1'b1}, 1'b1, 1'b0, 1'b1, 1'b0},
        '{'{ACT_REINIT, 1'b1, 1'b0, 8'd0,   1'b0}, 1'b1, 1'b0, 1'b1, 1'b1},
        '{'{ACT_REINIT, 1'b0, 1'b0, 8'd0,   1'b0}, 1'b1, 1'b0, 1'b1, 1'b0}
    };

    // The last two settings are drawn at random before the phases start.
    phase_t plan [9] = '{
        '{8'd20,  8'd30,  8'd3,   25, 15, 1,   6,   200, 1'b0},
        '{8'd0,   8'd0,   8'd0,   20, 10, 1,   4,   150, 1'b0},
        '{8'd100, 8'd100, 8'd1,   20, 10, 1,   5,   200, 1'b1},
        '{8'hFF,  8'hFF,  8'd2,   25, 10, 1,   5,   120, 1'b0},
        '{8'd40,  8'd60,  8'd255, 0,  0,  240, 300, 600, 1'b0},
        '{8'd10,  8'd90,  8'd5,   30, 15, 1,   10,  200, 1'b0},
        '{8'd70,  8'd20,  8'd4,   25, 15, 1,   8,   120, 1'b0},
        '{8'd0,   8'd0,   8'd0,   20, 15, 1,   8,   150, 1'b0},
        '{8'd0,   8'd0,   8'd0,   20, 15, 1,   8,   150, 1'b0}
    };

    battery_power_saving_mode_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t mode_result(logic st, logic ch, logic sv);
        result_t r;
        r.status = st;
        r.state_changed = ch;
        r.saving_mode = sv;
        r.seconds_on = ~sv;
        r.net_auto_on = ~sv;
        r.rtc_interval_ms = sv ? RTC_SAVING_MS : RTC_NORMAL_MS;
        r.sensor_interval_ms = sv ? SENSOR_SAVING_MS : SENSOR_NORMAL_MS;
        r.battery_interval_ms = sv ? BATTERY_SAVING_MS : BATTERY_NORMAL_MS;
        return r;
    endfunction

    function automatic void restart_run();
        run_dir = auto_latch;
        run_len = 8'd0;
    endfunction

    function automatic logic wanted_mode();
        return !host_present && (manual_req || auto_latch);
    endfunction

    function automatic result_t advance_mode(item_t ev);
        logic prior;
        logic want;
        logic rejected;
        prior = saving_now;
        rejected = 1'b0;
        case (ev.action)
            ACT_REINIT:
            begin
                host_present = 1'b0;
                seen_sample = 1'b0;
                auto_latch = 1'b0;
                run_dir = 1'b0;
                run_len = 8'd0;
                manual_req = ev.manual_saving;
                saving_now = ev.manual_saving;
            end
            ACT_MANUAL:
            begin
                if (ev.manual_saving != manual_req)
                begin
                    manual_req = ev.manual_saving;
                    restart_run();
                    saving_now = wanted_mode();
                end
            end
            ACT_SAMPLE:
            begin
                if (ev.reading_ok && ev.charge_level > PERCENT_MAX)
                begin
                    rejected = 1'b1;
                end
                else if (!ev.reading_ok)
                begin
                    restart_run();
                end
                else if (host_present)
                begin
                    seen_sample = 1'b1;
                    auto_latch = 1'b0;
                    restart_run();
                end
                else if (!seen_sample)
                begin
                    seen_sample = 1'b1;
                    auto_latch = (ev.charge_level <= {1'b0, enter_lvl});
                    saving_now = wanted_mode();
                    restart_run();
                end
                else
                begin
                    want = auto_latch;
                    if (!auto_latch && ev.charge_level <= {1'b0, enter_lvl})
                        want = 1'b1;
                    else if (auto_latch && ev.charge_level >= {1'b0, exit_lvl})
                        want = 1'b0;
                    if (want == auto_latch)
                    begin
                        restart_run();
                    end
                    else if (run_dir != want)
                    begin
                        run_dir = want;
                        run_len = 8'd1;
                    end
                    else
                    begin
                        if (run_len != COUNT_MAX)
                            run_len = run_len + 8'd1;
                        if (run_len >= confirm_need)
                        begin
                            auto_latch = want;
                            saving_now = wanted_mode();
                            restart_run();
                        end
                    end
                end
            end
            default:
            begin
                if (ev.usb_connected != host_present)
                begin
                    host_present = ev.usb_connected;
                    if (ev.usb_connected)
                    begin
                        auto_latch = 1'b0;
                        seen_sample = 1'b1;
                    end
                    restart_run();
                    saving_now = wanted_mode();
                end
            end
        endcase
        return mode_result(rejected, saving_now != prior, saving_now);
    endfunction

    function automatic item_t next_event(phase_t ph);
        item_t ev;
        int    pick;
        int    lim;
        ev.manual_saving = 1'($urandom_range(0, 1));
        ev.usb_connected = 1'($urandom_range(0, 1));
        ev.reading_ok = 1'b1;
        ev.charge_level = 8'($urandom_range(0, 255));
        ev.action = ACT_SAMPLE;
        if ($urandom_range(0, 99) < ph.noise)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                ev.action = ACT_REINIT;
            else if (pick <= 3)
                ev.action = ACT_MANUAL;
            else if (pick <= 5)
            begin
                ev.action = ACT_USB;
                ev.usb_connected = ($urandom_range(0, 3) == 0);
            end
            else if (pick <= 7)
                ev.reading_ok = 1'b0;
            else
                ev.charge_level = 8'($urandom_range(101, 255));
            return ev;
        end
        if (run_left == 0)
        begin
            low_side = ~low_side;
            run_left = $urandom_range(ph.min_run, ph.max_run);
        end
        run_left--;
        if ($urandom_range(0, 99) < ph.wild)
            ev.charge_level = 8'($urandom_range(0, 100));
        else if (low_side)
        begin
            lim = (enter_lvl > 7'd100) ? 100 : int'(enter_lvl);
            ev.charge_level = 8'($urandom_range(0, lim));
        end
        else
        begin
            lim = (exit_lvl > 7'd100) ? 100 : int'(exit_lvl);
            ev.charge_level = 8'($urandom_range(lim, 100));
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    task automatic check_report(input logic [55:0] word);
        result_t got;
        result_t want;
        got.status = word[0];
        got.state_changed = word[1];
        got.saving_mode = word[2];
        got.seconds_on = word[3];
        got.net_auto_on = word[4];
        got.rtc_interval_ms = word[20:5];
        got.sensor_interval_ms = word[36:21];
        got.battery_interval_ms = word[52:37];
        if (mode_reports_due.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
            results_seen++;
            return;
        end
        want = mode_reports_due.pop_front();
        compare_field("status", 16'(got.status), 16'(want.status));
        compare_field("state_changed", 16'(got.state_changed), 16'(want.state_changed));
        compare_field("saving_mode", 16'(got.saving_mode), 16'(want.saving_mode));
        compare_field("seconds_on", 16'(got.seconds_on), 16'(want.seconds_on));
        compare_field("net_auto_on", 16'(got.net_auto_on), 16'(want.net_auto_on));
        compare_field("rtc_interval_ms", got.rtc_interval_ms, want.rtc_interval_ms);
        compare_field("sensor_interval_ms", got.sensor_interval_ms, want.sensor_interval_ms);
        compare_field("battery_interval_ms", got.battery_interval_ms,
                      want.battery_interval_ms);
        compare_field("zero fill", 16'(word[55:53]), 16'd0);
        results_seen++;
    endtask

    task automatic send_event(input item_t ev, input logic pinned, input result_t pin_res);
        int      gap;
        result_t model;
        if ($urandom_range(0, 29) == 0)
            sender_calm = ~sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= ev.action;
        s_tdata <= {5'd0, ev.usb_connected, ev.charge_level, ev.reading_ok,
                    ev.manual_saving};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model = advance_mode(ev);
        mode_reports_due.push_back(pinned ? pin_res : model);
        events_sent++;
        mode_flips += int'(model.state_changed);
        rejects += int'(model.status);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [7:0] enter_raw, input logic [7:0] exit_raw,
                                  input logic [7:0] confirm_raw);
        logic [1:0] regs [3];
        logic [7:0] vals [3];
        regs = '{CFG_ENTER, CFG_EXIT, CFG_CONFIRM};
        vals = '{enter_raw, exit_raw, confirm_raw};
        s_tvalid <= 1'b0;
        while (mode_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (regs[i])
                CFG_ENTER:   enter_lvl = vals[i][6:0];
                CFG_EXIT:    exit_lvl = vals[i][6:0];
                default:     confirm_need = vals[i];
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                     IDLE_LIMIT, mode_reports_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                sink_calm = ~sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 18);
            if (hold_off_req)
            begin
                stall = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            check_report(m_tdata);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        result_t pin_res;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            pin_res = mode_result(script[i].p_status, script[i].p_changed, script[i].p_saving);
            send_event(script[i].ev, script[i].pinned, pin_res);
        end

        for (int p = 7; p < 9; p++)
        begin
            plan[p].enter_raw = 8'($urandom_range(0, 100));
            plan[p].exit_raw = 8'($urandom_range(0, 100));
            plan[p].confirm_raw = 8'($urandom_range(0, 8));
        end

        foreach (plan[p])
        begin
            write_settings(plan[p].enter_raw, plan[p].exit_raw, plan[p].confirm_raw);
            settings_used++;
            run_left = 0;
            if (plan[p].squeeze)
                hold_off_req = 1'b1;
            for (int n = 0; n < plan[p].count; n++)
                send_event(next_event(plan[p]), 1'b0, pin_res);
        end

        s_tvalid <= 1'b0;
        while (mode_reports_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d events over %0d register settings: %0d rejected samples,",
                 events_sent, settings_used, rejects);
        $display("%0d mode changes, confirm counts 0 to 255; %0d results compared, %0d wrong.",
                 mode_flips, results_seen, errors);
        if (errors == 0 && mode_reports_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/bpsm_pkg.sv
src/bpsm_cfg.sv
src/bpsm_ctrl.sv
src/battery_power_saving_mode_control.sv
tb/tb_battery_power_saving_mode_control.sv
